// ----- rtl/core/elsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package elsp_pkg;

	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_N      = 8'h6e;
	localparam logic [7:0] CHAR_QUOTE  = 8'h22;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0d;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOL  = 2'd1,
		KIND_END  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_DOLLAR_END = 2'd1,
		ERR_OPEN_QUOTE = 2'd2
	} err_t;

	// source of the out_byte field
	typedef enum logic [1:0] {
		SEL_PEND   = 2'd0,
		SEL_DOLLAR = 2'd1,
		SEL_BYTE   = 2'd2,
		SEL_ZERO   = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		MODE_START     = 2'd0,
		MODE_START_ESC = 2'd1,
		MODE_COPY      = 2'd2,
		MODE_COPY_ESC  = 2'd3
	} mode_t;

	// ordered: the sequencer relies on the step order
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_FLUSH  = 3'd1,
		ST_DOLLAR = 3'd2,
		ST_BYTE   = 3'd3,
		ST_EOL    = 3'd4,
		ST_FINAL  = 3'd5
	} state_t;

	typedef struct packed {
		logic zero;
		logic ws;
		logic dollar;
		logic is_n;
		logic quote;
	} cls_t;

	typedef struct packed {
		logic  accept;      // load input byte
		logic  push_in;     // hold input byte as whitespace
		logic  push_byte;   // hold latched byte as whitespace
		logic  pend_clear;
		logic  line_inc;
		logic  line_clear;
		logic  flush_start; // prefetch entry 0
		logic  flush_next;  // entry consumed, fetch next
		logic  emit;
		kind_t kind;
		sel_t  sel;
		err_t  code;
		logic  last;
	} ctrl_cmd_t;

	typedef struct packed {
		cls_t in_cls;
		logic pend_empty;
		logic flush_last;
		logic out_free;
	} dp_status_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.zero   = (c == CHAR_NUL);
		r.ws     = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
		r.dollar = (c == CHAR_DOLLAR);
		r.is_n   = (c == CHAR_N);
		r.quote  = (c == CHAR_QUOTE);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/escaped_line_splitter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte string into lines at every unquoted "$n", trimming leading
// and trailing whitespace. Input bytes enter on the s_ channel, one request
// per byte, with byte 0 ending the string. Results leave on the m_ channel:
// tuser carries the kind (data, end of line, end of string, error), tdata the
// copied byte, error code and line count, tlast marks the final result of
// one input byte. A byte that gives no result (skipped or held whitespace,
// a '$' waiting for its partner) is taken while the sequencer stays idle.
// Otherwise the sequencer steps, in this order, through one result for
// each flushed whitespace byte, the escape '$', the copied byte, the end of
// line and the end of string or error, one result per cycle while the
// receiver takes them; the held bytes come from a store with separate
// write and read ports and registered read, prefetched at acceptance.
// Reset empties the whitespace store, clears the line count and returns to
// line start; the same happens after every end-of-string or error result.
// When the receiver stalls, the output register holds its result, the
// sequencer waits and s_tready stays low until the byte's results are out.

module escaped_line_splitter_core #(
	parameter int PENDING_DEPTH = 16,  // held whitespace bytes, 1..256
	parameter int MAX_LINES     = 255  // line count saturation, 1..255 (larger values act as 255)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [9:8] error_code,
	                                    // [17:10] line_count, [23:18] zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last result of this input byte
);

	elsp_pkg::ctrl_cmd_t  cmd;
	elsp_pkg::dp_status_t status;

	// sequencer: parse mode, quote state, result steps per request
	elsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: whitespace store, line counter, output register
	elsp_dp #(
		.PENDING_DEPTH (PENDING_DEPTH),
		.MAX_LINES     (MAX_LINES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- rtl/core/elsp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module elsp_dp #(
	parameter int PENDING_DEPTH = 16,
	parameter int MAX_LINES     = 255
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             s_tdata,
	input  wire elsp_pkg::ctrl_cmd_t    cmd,
	output elsp_pkg::dp_status_t        status,
	input  wire logic                   m_tready,
	output logic                        m_tvalid,
	output logic [23:0]                 m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);

	localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int LineCapInt = (MAX_LINES < 255) ? MAX_LINES : 255;
	localparam logic [7:0] LINE_CAP = 8'(LineCapInt);

	logic [7:0]    pend_mem [PENDING_DEPTH];
	logic [7:0]    rd_data_q;
	logic [7:0]    byte_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    lines_q;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_byte_q;
	logic [1:0]    out_code_q;
	logic [7:0]    out_lines_q;
	logic          out_last_q;

	logic          wr_en;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          flush_last;
	logic [7:0]    sel_byte;

	assign flush_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign wr_en   = (cmd.push_in || cmd.push_byte) && (count_q != CW'(PENDING_DEPTH));
	assign wr_data = cmd.push_in ? s_tdata : byte_q;
	assign rd_en   = cmd.flush_start || (cmd.flush_next && !flush_last);
	assign rd_addr = cmd.flush_start ? '0 : idx_q + AW'(1);

	assign status.in_cls     = elsp_pkg::classify(s_tdata);
	assign status.pend_empty = (count_q == '0);
	assign status.flush_last = flush_last;
	assign status.out_free   = !out_valid_q || m_tready;

	// pending whitespace store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pend_mem[count_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= pend_mem[rd_addr];
		end
		if (cmd.accept) begin
			byte_q <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			lines_q <= '0;
		end else begin
			if (cmd.pend_clear) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.flush_start) begin
				idx_q <= '0;
			end else if (cmd.flush_next) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.line_clear) begin
				lines_q <= '0;
			end else if (cmd.line_inc && (lines_q < LINE_CAP)) begin
				lines_q <= lines_q + 8'd1;
			end
		end
	end

	always_comb begin
		unique case (cmd.sel)
			elsp_pkg::SEL_PEND:   sel_byte = rd_data_q;
			elsp_pkg::SEL_DOLLAR: sel_byte = elsp_pkg::CHAR_DOLLAR;
			elsp_pkg::SEL_BYTE:   sel_byte = byte_q;
			default:              sel_byte = 8'd0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q  <= cmd.kind;
			out_byte_q  <= sel_byte;
			out_code_q  <= cmd.code;
			out_lines_q <= lines_q;
			out_last_q  <= cmd.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_lines_q, out_code_q, out_byte_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/elsp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module elsp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire elsp_pkg::dp_status_t status,
	output elsp_pkg::ctrl_cmd_t    cmd
);

	// result steps still owed for the current request
	typedef struct packed {
		logic              dollar;
		logic              byte_out;
		logic              hold;       // hold latched byte after the dollar
		logic              eol;
		logic              eol_count;  // empty line: count the next line too
		logic              final_res;
		elsp_pkg::kind_t   final_kind;
		elsp_pkg::err_t    final_code;
	} plan_t;

	elsp_pkg::state_t state_q, state_d;
	elsp_pkg::mode_t  mode_q, mode_d;
	logic             quotes_q, quotes_d;
	plan_t            plan_q, plan_d;
	logic             flush_go;
	elsp_pkg::cls_t   cls;

	function automatic elsp_pkg::state_t step_after(input elsp_pkg::state_t cur, input plan_t p);
		elsp_pkg::state_t nxt;
		priority if (p.dollar && (cur < elsp_pkg::ST_DOLLAR)) nxt = elsp_pkg::ST_DOLLAR;
		else if (p.byte_out && (cur < elsp_pkg::ST_BYTE)) nxt = elsp_pkg::ST_BYTE;
		else if (p.eol && (cur < elsp_pkg::ST_EOL)) nxt = elsp_pkg::ST_EOL;
		else if (p.final_res && (cur < elsp_pkg::ST_FINAL)) nxt = elsp_pkg::ST_FINAL;
		else nxt = elsp_pkg::ST_IDLE;
		return nxt;
	endfunction

	assign cls = status.in_cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= elsp_pkg::ST_IDLE;
			mode_q   <= elsp_pkg::MODE_START;
			quotes_q <= 1'b0;
			plan_q   <= '0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			quotes_q <= quotes_d;
			plan_q   <= plan_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		quotes_d = quotes_q;
		plan_d   = plan_q;
		flush_go = 1'b0;
		cmd      = '0;
		cmd.kind = elsp_pkg::KIND_DATA;
		cmd.sel  = elsp_pkg::SEL_ZERO;
		cmd.code = elsp_pkg::ERR_NONE;
		s_tready = (state_q == elsp_pkg::ST_IDLE);

		unique case (state_q)
			elsp_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					plan_d = '0;
					unique case (mode_q)
						elsp_pkg::MODE_START: begin
							priority if (cls.zero) begin
								plan_d.final_res  = 1'b1;
								plan_d.final_kind = elsp_pkg::KIND_END;
							end else if (cls.ws) begin
								// leading whitespace dropped
							end else if (cls.dollar) begin
								mode_d = elsp_pkg::MODE_START_ESC;
							end else begin
								cmd.line_inc = 1'b1;
								if (cls.quote) quotes_d = 1'b1;
								plan_d.byte_out = 1'b1;
								mode_d = elsp_pkg::MODE_COPY;
							end
						end
						elsp_pkg::MODE_START_ESC: begin
							priority if (cls.zero) begin
								plan_d.final_res  = 1'b1;
								plan_d.final_kind = elsp_pkg::KIND_ERR;
								plan_d.final_code = elsp_pkg::ERR_DOLLAR_END;
							end else if (cls.is_n) begin
								cmd.line_inc = 1'b1;
								plan_d.eol = 1'b1;
								plan_d.eol_count = 1'b1;
								mode_d = elsp_pkg::MODE_COPY;
							end else begin
								cmd.line_inc = 1'b1;
								plan_d.dollar   = 1'b1;
								plan_d.byte_out = !cls.ws;
								plan_d.hold     = cls.ws;
								mode_d = elsp_pkg::MODE_COPY;
							end
						end
						elsp_pkg::MODE_COPY: begin
							priority if (cls.zero) begin
								plan_d.eol = 1'b1;
								plan_d.final_res = 1'b1;
								if (quotes_q) begin
									plan_d.final_kind = elsp_pkg::KIND_ERR;
									plan_d.final_code = elsp_pkg::ERR_OPEN_QUOTE;
								end else begin
									plan_d.final_kind = elsp_pkg::KIND_END;
								end
							end else if (cls.dollar) begin
								mode_d = elsp_pkg::MODE_COPY_ESC;
							end else begin
								if (cls.quote) quotes_d = !quotes_q;
								if (cls.ws) begin
									cmd.push_in = 1'b1;
								end else begin
									flush_go = !status.pend_empty;
									plan_d.byte_out = 1'b1;
								end
							end
						end
						default: begin
							priority if (cls.zero) begin
								plan_d.final_res  = 1'b1;
								plan_d.final_kind = elsp_pkg::KIND_ERR;
								plan_d.final_code = elsp_pkg::ERR_DOLLAR_END;
							end else if (cls.is_n && !quotes_q) begin
								plan_d.eol = 1'b1;
								mode_d = elsp_pkg::MODE_START;
							end else begin
								flush_go = !status.pend_empty;
								plan_d.dollar   = 1'b1;
								plan_d.byte_out = !cls.ws;
								plan_d.hold     = cls.ws;
								mode_d = elsp_pkg::MODE_COPY;
							end
						end
					endcase
					cmd.flush_start = flush_go;
					state_d = flush_go ? elsp_pkg::ST_FLUSH
						: step_after(elsp_pkg::ST_IDLE, plan_d);
				end
			end
			elsp_pkg::ST_FLUSH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = elsp_pkg::SEL_PEND;
					cmd.flush_next = 1'b1;
					cmd.last = status.flush_last
						&& (step_after(elsp_pkg::ST_FLUSH, plan_q) == elsp_pkg::ST_IDLE);
					if (status.flush_last) begin
						cmd.pend_clear = 1'b1;
						state_d = step_after(elsp_pkg::ST_FLUSH, plan_q);
					end
				end
			end
			elsp_pkg::ST_DOLLAR: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = elsp_pkg::SEL_DOLLAR;
					cmd.push_byte = plan_q.hold;
					state_d  = step_after(elsp_pkg::ST_DOLLAR, plan_q);
					cmd.last = (state_d == elsp_pkg::ST_IDLE);
				end
			end
			elsp_pkg::ST_BYTE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = elsp_pkg::SEL_BYTE;
					state_d  = step_after(elsp_pkg::ST_BYTE, plan_q);
					cmd.last = (state_d == elsp_pkg::ST_IDLE);
				end
			end
			elsp_pkg::ST_EOL: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = elsp_pkg::KIND_EOL;
					cmd.pend_clear = 1'b1;
					cmd.line_inc = plan_q.eol_count;
					state_d  = step_after(elsp_pkg::ST_EOL, plan_q);
					cmd.last = (state_d == elsp_pkg::ST_IDLE);
				end
			end
			elsp_pkg::ST_FINAL: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = plan_q.final_kind;
					cmd.code = plan_q.final_code;
					cmd.last = 1'b1;
					cmd.line_clear = 1'b1;
					cmd.pend_clear = 1'b1;
					mode_d   = elsp_pkg::MODE_START;
					quotes_d = 1'b0;
					state_d  = elsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = elsp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
